[sv/qrft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrft_pkg
// Shared widths, field type codes and the response record of the quoted row
// field tokenizer.
// ----------------------------------------------------------------------------
package qrft_pkg;

   // row field limit; the field counter saturates one below it
   localparam int MAX_FIELDS  = 4096;
   localparam int FIELD_CNT_W = $clog2(MAX_FIELDS);
   localparam int CFG_W       = 12;
   localparam int CMP_W       = (FIELD_CNT_W > CFG_W) ? FIELD_CNT_W : CFG_W;

   localparam int BYTE_W  = 8;
   localparam int FTYPE_W = 3;

   // field type codes
   localparam logic [FTYPE_W-1:0] FT_STRING = 3'd0;
   localparam logic [FTYPE_W-1:0] FT_INT    = 3'd1;
   localparam logic [FTYPE_W-1:0] FT_FLOAT  = 3'd2;
   localparam logic [FTYPE_W-1:0] FT_TRUE   = 3'd3;
   localparam logic [FTYPE_W-1:0] FT_FALSE  = 3'd4;
   localparam logic [FTYPE_W-1:0] FT_NULL   = 3'd5;

   // response queue
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // one response item
   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               out_valid;
      logic               field_end;
      logic [FTYPE_W-1:0] field_type;
      logic               row_end;
      logic               count_error;
      logic               last;
   } res_type;

   // responses produced by one request
   typedef struct packed {
      logic [1:0] cnt;
      res_type    r0;
      res_type    r1;
   } par_out_type;

endpackage : qrft_pkg
`default_nettype wire

[sv/qrft_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrft_req_if / qrft_rsp_if
// Valid/ready channels for row bytes in and tokenizer responses out.
// ----------------------------------------------------------------------------
interface qrft_req_if;
   import qrft_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] char_byte;
   logic              has_byte;
   logic              line_end;

   modport source (output valid, output char_byte, output has_byte, output line_end,
                   input ready);
   modport sink   (input valid, input char_byte, input has_byte, input line_end,
                   output ready);
endinterface : qrft_req_if

interface qrft_rsp_if;
   import qrft_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               out_valid;
   logic               field_end;
   logic [FTYPE_W-1:0] field_type;
   logic               row_end;
   logic               count_error;
   logic               last;

   modport source (output valid, output out_byte, output out_valid, output field_end,
                   output field_type, output row_end, output count_error, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input field_end,
                   input field_type, input row_end, input count_error, input last,
                   output ready);
endinterface : qrft_rsp_if
`default_nettype wire

[sv/qrft_parse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrft_parse
// Parser state and the per-request decode: quoting, escapes, field typing,
// field count and the up to two responses one request produces.
// ----------------------------------------------------------------------------
module qrft_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic [qrft_pkg::BYTE_W-1:0] char_byte,
   input  wire logic                        has_byte,
   input  wire logic                        line_end,
   input  wire logic [qrft_pkg::CFG_W-1:0]  expected_fields,
   output qrft_pkg::par_out_type            par_out
);
   import qrft_pkg::*;

   // parser modes
   localparam logic [2:0] M_LINE_START  = 3'd0;
   localparam logic [2:0] M_FIELD_START = 3'd1;
   localparam logic [2:0] M_UNQUOTED    = 3'd2;
   localparam logic [2:0] M_QUOTED      = 3'd3;
   localparam logic [2:0] M_ESCAPE      = 3'd4;
   localparam logic [2:0] M_AFTER_CLOSE = 3'd5;
   localparam logic [2:0] M_ROW_DONE    = 3'd6;

   // literal match progress
   localparam logic [3:0] LIT_START = 4'd0;
   localparam logic [3:0] LIT_T     = 4'd1;
   localparam logic [3:0] LIT_TRUE  = 4'd4;
   localparam logic [3:0] LIT_F     = 4'd5;
   localparam logic [3:0] LIT_FALSE = 4'd9;
   localparam logic [3:0] LIT_N     = 4'd10;
   localparam logic [3:0] LIT_NULL  = 4'd13;
   localparam logic [3:0] LIT_DEAD  = 4'd15;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_NONE  = 8'h00;

   localparam logic [4:0] DCOUNT_MAX = 5'd31;
   localparam logic [4:0] INT_DIGITS = 5'd18;
   localparam logic [FIELD_CNT_W-1:0] FIELDS_MAX = FIELD_CNT_W'(MAX_FIELDS - 1);

   // unquoted field classification state
   typedef struct packed {
      logic       nonzero;
      logic       digit;
      logic       dot;
      logic       num_ok;
      logic [3:0] lit;
      logic [4:0] dcount;
   } cls_type;

   localparam cls_type CLS_CLEAR = '{nonzero: 1'b0, digit: 1'b0, dot: 1'b0, num_ok: 1'b1,
                                    lit: LIT_START, dcount: 5'd0};

   // next byte expected by a partial literal match
   function automatic logic [7:0] lit_next(input logic [3:0] lit);
      logic [7:0] e;
      case (lit)
         4'd1:    e = CH_R;
         4'd2:    e = CH_U;
         4'd3:    e = CH_E;
         4'd5:    e = CH_A;
         4'd6:    e = CH_L;
         4'd7:    e = CH_S;
         4'd8:    e = CH_E;
         4'd10:   e = CH_U;
         4'd11:   e = CH_L;
         4'd12:   e = CH_L;
         default: e = CH_NONE;
      endcase
      return e;
   endfunction

   function automatic cls_type classify(input cls_type s, input logic [7:0] c);
      cls_type    t;
      logic [7:0] e;
      t = s;
      e = lit_next(s.lit);
      // number shape: a leading sign is allowed only as the first byte
      if (!s.nonzero && (c == CH_MINUS || c == CH_PLUS)) begin
         t.num_ok = s.num_ok;
      end else if (c >= CH_0 && c <= CH_9) begin
         t.digit = 1'b1;
         if (s.dcount != DCOUNT_MAX) t.dcount = s.dcount + 5'd1;
      end else if (c == CH_DOT && !s.dot) begin
         t.dot = 1'b1;
      end else begin
         t.num_ok = 1'b0;
      end
      // literal match
      if (s.lit == LIT_START) begin
         t.lit = (c == CH_T) ? LIT_T : (c == CH_F) ? LIT_F : (c == CH_N) ? LIT_N : LIT_DEAD;
      end else begin
         t.lit = (e != CH_NONE && c == e) ? s.lit + 4'd1 : LIT_DEAD;
      end
      t.nonzero = 1'b1;
      return t;
   endfunction

   function automatic logic [FTYPE_W-1:0] unq_type(input cls_type s);
      logic [FTYPE_W-1:0] ft;
      if (s.lit == LIT_TRUE)           ft = FT_TRUE;
      else if (s.lit == LIT_FALSE)     ft = FT_FALSE;
      else if (s.lit == LIT_NULL)      ft = FT_NULL;
      else if (s.num_ok && s.digit)    ft = (s.dot || s.dcount > INT_DIGITS) ? FT_FLOAT : FT_INT;
      else                             ft = FT_STRING;
      return ft;
   endfunction

   function automatic logic [FIELD_CNT_W-1:0] sat_inc(input logic [FIELD_CNT_W-1:0] f);
      return (f < FIELDS_MAX) ? f + FIELD_CNT_W'(1) : f;
   endfunction

   function automatic res_type mk_byte(input logic [7:0] b);
      res_type r;
      r = '0;
      r.out_byte  = b;
      r.out_valid = 1'b1;
      return r;
   endfunction

   function automatic logic can_merge(input res_type r);
      return r.out_valid && !r.field_end && !r.row_end;
   endfunction

   logic [2:0]             mode_ff, mode_in, mode1;
   logic [FIELD_CNT_W-1:0] fields_ff, fields_in, fields1, fields2;
   cls_type                cls_ff, cls_in, cls1;

   // byte step results
   logic [7:0]         b0, b1;
   logic [1:0]         nb;
   logic               a_has, a_fe, a_re, a_err;
   logic [FTYPE_W-1:0] a_type;
   // line end results
   logic               eb, m_has, m_fe, m_re, m_err;
   logic [FTYPE_W-1:0] m_type;

   logic [CMP_W-1:0] exp_cmp;
   assign exp_cmp = CMP_W'(expected_fields);

   // byte step
   always_comb begin
      mode1   = mode_ff;
      fields1 = fields_ff;
      cls1    = cls_ff;
      b0      = char_byte;
      b1      = char_byte;
      nb      = 2'd0;
      a_has   = 1'b0;
      a_fe    = 1'b0;
      a_re    = 1'b0;
      a_err   = 1'b0;
      a_type  = FT_STRING;
      if (has_byte) begin
         case (mode_ff)
            M_LINE_START, M_FIELD_START: begin
               if (mode_ff == M_LINE_START && char_byte == CH_SPACE) begin
                  mode1 = mode_ff;
               end else if (char_byte == CH_QUOTE) begin
                  mode1 = M_QUOTED;
               end else if (char_byte == CH_COMMA) begin
                  a_has   = 1'b1;
                  a_fe    = 1'b1;
                  a_type  = unq_type(cls_ff);
                  fields1 = sat_inc(fields_ff);
                  cls1    = CLS_CLEAR;
                  mode1   = M_FIELD_START;
               end else begin
                  cls1  = classify(cls_ff, char_byte);
                  nb    = 2'd1;
                  mode1 = M_UNQUOTED;
               end
            end
            M_UNQUOTED: begin
               if (char_byte == CH_COMMA) begin
                  a_has   = 1'b1;
                  a_fe    = 1'b1;
                  a_type  = unq_type(cls_ff);
                  fields1 = sat_inc(fields_ff);
                  cls1    = CLS_CLEAR;
                  mode1   = M_FIELD_START;
               end else begin
                  cls1 = classify(cls_ff, char_byte);
                  nb   = 2'd1;
               end
            end
            M_QUOTED: begin
               if (char_byte == CH_BSL) begin
                  mode1 = M_ESCAPE;
               end else if (char_byte == CH_QUOTE) begin
                  a_has   = 1'b1;
                  a_fe    = 1'b1;
                  a_type  = FT_STRING;
                  fields1 = sat_inc(fields_ff);
                  cls1    = CLS_CLEAR;
                  mode1   = M_AFTER_CLOSE;
               end else begin
                  nb = 2'd1;
               end
            end
            M_ESCAPE: begin
               nb    = 2'd1;
               mode1 = M_QUOTED;
               if (char_byte == CH_N) begin
                  b0 = CH_LF;
               end else if (char_byte != CH_BSL && char_byte != CH_QUOTE) begin
                  // unknown escape keeps the backslash
                  b0 = CH_BSL;
                  nb = 2'd2;
               end
            end
            M_AFTER_CLOSE: begin
               if (char_byte == CH_COMMA) begin
                  mode1 = M_FIELD_START;
               end else begin
                  a_has = 1'b1;
                  a_re  = 1'b1;
                  a_err = CMP_W'(fields_ff) != exp_cmp;
                  mode1 = M_ROW_DONE;
               end
            end
            default: begin
               mode1 = mode_ff;
            end
         endcase
      end
   end

   // line end step
   always_comb begin
      eb      = 1'b0;
      m_has   = 1'b0;
      m_fe    = 1'b0;
      m_re    = 1'b0;
      m_err   = 1'b0;
      m_type  = FT_STRING;
      fields2 = sat_inc(fields1);
      case (mode1)
         M_LINE_START, M_FIELD_START, M_UNQUOTED: begin
            m_has  = 1'b1;
            m_fe   = 1'b1;
            m_re   = 1'b1;
            m_type = unq_type(cls1);
            m_err  = CMP_W'(fields2) != exp_cmp;
         end
         M_QUOTED, M_ESCAPE: begin
            // dangling backslash at row end is kept
            eb    = (mode1 == M_ESCAPE);
            m_has = 1'b1;
            m_fe  = 1'b1;
            m_re  = 1'b1;
            m_err = CMP_W'(fields2) != exp_cmp;
         end
         M_AFTER_CLOSE: begin
            m_has = 1'b1;
            m_re  = 1'b1;
            m_err = CMP_W'(fields1) != exp_cmp;
         end
         default: begin
            m_has = 1'b0;
         end
      endcase
      if (!line_end) begin
         eb    = 1'b0;
         m_has = 1'b0;
      end
   end

   // response assembly; end marks fold into a preceding byte-only response
   always_comb begin
      res_type    lst [4];
      logic [1:0] n;
      logic [1:0] idx;
      for (int i = 0; i < 4; i++) lst[i] = '0;
      n   = 2'd0;
      idx = 2'd0;
      if (nb != 2'd0) begin
         lst[n] = mk_byte(b0);
         n      = n + 2'd1;
      end
      if (nb == 2'd2) begin
         lst[n] = mk_byte(b1);
         n      = n + 2'd1;
      end
      if (a_has) begin
         if (n != 2'd0 && can_merge(lst[n - 2'd1])) begin
            idx = n - 2'd1;
         end else begin
            idx = n;
            n   = n + 2'd1;
         end
         if (a_fe) begin
            lst[idx].field_end  = 1'b1;
            lst[idx].field_type = a_type;
         end
         if (a_re) begin
            lst[idx].row_end     = 1'b1;
            lst[idx].count_error = a_err;
         end
      end
      if (eb) begin
         lst[n] = mk_byte(CH_BSL);
         n      = n + 2'd1;
      end
      if (m_has) begin
         if (n != 2'd0 && can_merge(lst[n - 2'd1])) begin
            idx = n - 2'd1;
         end else begin
            idx = n;
            n   = n + 2'd1;
         end
         if (m_fe) begin
            lst[idx].field_end  = 1'b1;
            lst[idx].field_type = m_type;
         end
         lst[idx].row_end     = 1'b1;
         lst[idx].count_error = m_err;
      end
      if (n != 2'd0) lst[n - 2'd1].last = 1'b1;
      par_out.cnt = n;
      par_out.r0  = lst[0];
      par_out.r1  = lst[1];
   end

   // next state
   always_comb begin
      mode_in   = mode1;
      fields_in = fields1;
      cls_in    = cls1;
      if (line_end) begin
         mode_in   = M_LINE_START;
         fields_in = '0;
         cls_in    = CLS_CLEAR;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_LINE_START;
         fields_ff <= '0;
         cls_ff    <= CLS_CLEAR;
      end else if (fire) begin
         mode_ff   <= mode_in;
         fields_ff <= fields_in;
         cls_ff    <= cls_in;
      end
   end

endmodule : qrft_parse
`default_nettype wire

[sv/qrft_rsp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrft_rsp_fifo
// Small response queue: takes up to two responses a cycle, drives the
// response channel one per cycle while the channel is ready.
// ----------------------------------------------------------------------------
module qrft_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  qrft_pkg::par_out_type      par_out,
   output logic                       space_ok,
   qrft_rsp_if.source                 rsp_port
);
   import qrft_pkg::*;

   res_type              mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]  count_ff, count_in, count_left;
   logic [1:0]           push_cnt;
   logic                 pop;
   res_type              head;

   assign push_cnt = push ? par_out.cnt : 2'd0;
   assign pop      = rsp_port.valid && rsp_port.ready;

   // room for a full request after this cycle's pop
   assign count_left = count_ff - RQ_CNT_W'(pop);
   assign space_ok   = count_left <= RQ_CNT_W'(RQ_DEPTH - 2);

   // pointers and fill level
   assign wr_ptr_in = wr_ptr_ff + RQ_PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + RQ_PTR_W'(pop);
   assign count_in  = count_left + RQ_CNT_W'(push_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ptr_ff] <= par_out.r0;
      if (push_cnt == 2'd2) mem_ff[wr_ptr_ff + RQ_PTR_W'(1)] <= par_out.r1;
   end

   // head of queue to the channel
   assign head                 = mem_ff[rd_ptr_ff];
   assign rsp_port.valid       = count_ff != '0;
   assign rsp_port.out_byte    = head.out_byte;
   assign rsp_port.out_valid   = head.out_valid;
   assign rsp_port.field_end   = head.field_end;
   assign rsp_port.field_type  = head.field_type;
   assign rsp_port.row_end     = head.row_end;
   assign rsp_port.count_error = head.count_error;
   assign rsp_port.last        = head.last;

endmodule : qrft_rsp_fifo
`default_nettype wire

[sv/quoted_row_field_tokenizer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_row_field_tokenizer_top
// Splits a table row into fields, decodes quoted escapes and types each
// unquoted field; flags rows whose field count is off.
// ----------------------------------------------------------------------------
// A request carries one row byte and/or a row end. It is captured in an input
// register and decoded from there against the parser state, producing zero,
// one or two responses into a four-entry response queue. One request is taken
// every cycle while the queue has room for two responses after this cycle's
// drain, so the sustained rate is one request per cycle when each request
// makes at most one response and the response channel is ready; the channel
// moves one response per cycle while ready is high, which bounds rows with
// many two-response requests (unknown escapes, and a closing quote or a comma
// that comes with the row end). expected_fields is written through
// csr_wr_en/csr_wr_data and resets to 1; write it only while the block is idle.
// ----------------------------------------------------------------------------
module quoted_row_field_tokenizer_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   qrft_req_if.sink                        req_port,
   qrft_rsp_if.source                      rsp_port,
   input  wire logic                       csr_wr_en,
   input  wire logic [qrft_pkg::CFG_W-1:0] csr_wr_data
);
   import qrft_pkg::*;

   logic [CFG_W-1:0]  exp_fields_ff;
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] char_ff;
   logic              has_byte_ff, line_end_ff;
   logic              fire, space_ok, req_take;
   par_out_type       par_out;

   // expected field count register
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_fields_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         exp_fields_ff <= csr_wr_data;
      end
   end

   // input register
   assign fire           = in_vld_ff && space_ok;
   assign req_port.ready = !in_vld_ff || fire;
   assign req_take       = req_port.valid && req_port.ready;
   assign in_vld_in      = req_take ? 1'b1 : (fire ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff     <= req_port.char_byte;
         has_byte_ff <= req_port.has_byte;
         line_end_ff <= req_port.line_end;
      end
   end

   // decode
   qrft_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .char_byte       (char_ff),
      .has_byte        (has_byte_ff),
      .line_end        (line_end_ff),
      .expected_fields (exp_fields_ff),
      .par_out         (par_out)
   );

   // response queue
   qrft_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .par_out  (par_out),
      .space_ok (space_ok),
      .rsp_port (rsp_port)
   );

   // a count error is only reported with a row end
   a_err_with_row: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.count_error |-> rsp_port.row_end)
      else $error("count error without row end");

   // a non-string type is only reported with a field end
   a_type_with_end: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.field_type != FT_STRING |-> rsp_port.field_end)
      else $error("field type without field end");

   // a row end in the first response of a request is marked last
   a_row_last: assert property (@(posedge clock) disable iff (reset)
      fire && par_out.cnt != 2'd0 && par_out.r0.row_end |-> par_out.r0.last)
      else $error("row end response not last");

   // the block is ready right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_port.ready)
      else $error("not ready after reset");

endmodule : quoted_row_field_tokenizer_top
`default_nettype wire
